// ===== rtl/pse_pkg.sv =====
// Shared types and constants for the postfix stack evaluator.
// Holds the stack geometry, symbol codes, item kinds, error codes and states.
// Used by every module of the block except pse_ram; depends on nothing.
package pse_pkg;

  localparam int StackDepth = 32;
  localparam int CntW       = $clog2(StackDepth + 1);
  localparam int AddrW      = $clog2(StackDepth);
  localparam int ValW       = 8;

  localparam logic [CntW-1:0] StackDepthC = CntW'(StackDepth);
  localparam logic [2:0]      DivLastStep = 3'(ValW - 1);

  localparam logic [7:0] CodeBias    = 8'd48;
  localparam logic [7:0] ChPlus      = 8'h2B;
  localparam logic [7:0] ChMinus     = 8'h2D;
  localparam logic [7:0] ChStar      = 8'h2A;
  localparam logic [7:0] ChSlash     = 8'h2F;
  localparam logic [7:0] ChPercent   = 8'h25;
  localparam logic [7:0] ChLeftPar   = 8'h28;
  localparam logic [7:0] ChRightPar  = 8'h29;
  localparam logic [7:0] ChHash      = 8'h23;

  typedef enum logic [2:0] {
    KIND_PUSH,
    KIND_NOP,
    KIND_ADD,
    KIND_SUB,
    KIND_MUL,
    KIND_DIV,
    KIND_MOD
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_UNDER = 2'd1,
    ERR_OVER  = 2'd2,
    ERR_DIVZ  = 2'd3
  } err_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_R,
    ST_CAP_R,
    ST_RD_L,
    ST_CAP_L,
    ST_EXEC,
    ST_DIV,
    ST_DIV_FIN,
    ST_PUSH,
    ST_FIN_RD,
    ST_FIN_CAP,
    ST_EMIT
  } state_e;

  typedef struct packed {
    kind_e             kind;
    logic [ValW-1:0]   value;
    logic              last;
  } item_t;

endpackage

// ===== rtl/postfix_stack_evaluator.sv =====
// Top level of the postfix stack evaluator.
// Depends on pse_pkg, pse_front, pse_back and (through pse_back) pse_ram.
//
// The slave stream carries one expression character per word in tdata, with
// tlast set on the final character. Operators + - * / % pop two values and
// push the result; parentheses and '#' are skipped; every other character
// pushes its code minus 48 onto a 32-entry stack of signed bytes.
// After the word marked tlast, one master word carries the popped top of
// stack and the first error seen, and the stack and error are then cleared.
// A two-word queue takes input words while the stack engine is busy.
// The stack engine handles one word at a time through a stack memory with one
// write port, one read port and registered reads; / and % use the
// one-bit-per-cycle restoring divider, and a tlast word adds the final pop
// and the output load.
// Reset empties the queue, the stack and the error; no clearing pass is run.
// When the receiver stalls, the result holds in the output register and the
// engine waits only when it has a further result to load.
module postfix_stack_evaluator
  import pse_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] symbol
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // [7:0] value, [9:8] status, [15:10] zero
);

  logic              item_valid;
  logic              item_ready;
  item_t             item;
  logic [ValW-1:0]   out_value;
  logic [1:0]        out_status;

  pse_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid_i),
    .s_ready_o    (s_axis_tready_o),
    .s_symbol_i   (s_axis_tdata_i),
    .s_last_i     (s_axis_tlast_i),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  pse_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_value_o  (out_value),
    .out_status_o (out_status)
  );

  assign m_axis_tdata_o = {6'b0, out_status, out_value};

endmodule

// ===== rtl/pse_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// Holds the value stack of the postfix stack evaluator; no dependencies.
module pse_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/pse_front.sv =====
// Front end: accepts symbol words, classifies them and queues them.
// Depends on pse_pkg for the item type and symbol codes.
module pse_front
  import pse_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  output logic        s_ready_o,
  input  logic [7:0]  s_symbol_i,
  input  logic        s_last_i,
  output logic        item_valid_o,
  input  logic        item_ready_i,
  output item_t       item_o
);

  item_t       slot_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  fill_q, fill_d;
  item_t       item_in;
  logic        push, pop;

  always_comb begin
    item_in.value = s_symbol_i - CodeBias;
    item_in.last  = s_last_i;
    unique case (s_symbol_i) inside
      ChPlus:     item_in.kind = KIND_ADD;
      ChMinus:    item_in.kind = KIND_SUB;
      ChStar:     item_in.kind = KIND_MUL;
      ChSlash:    item_in.kind = KIND_DIV;
      ChPercent:  item_in.kind = KIND_MOD;
      ChLeftPar,
      ChRightPar,
      ChHash:     item_in.kind = KIND_NOP;
      default:    item_in.kind = KIND_PUSH;
    endcase
  end

  assign s_ready_o    = (fill_q != 2'd2);
  assign item_valid_o = (fill_q != 2'd0);
  assign item_o       = slot_q[rd_ptr_q];
  assign push         = s_valid_i && s_ready_o;
  assign pop          = item_valid_o && item_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

// ===== rtl/pse_back.sv =====
// Back end: stack sequencer with an iterative divider and an output register.
// Depends on pse_pkg and instantiates pse_ram for the value stack.
module pse_back
  import pse_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             item_valid_i,
  output logic             item_ready_o,
  input  item_t            item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ValW-1:0]  out_value_o,
  output logic [1:0]       out_status_o
);

  state_e             state_q, state_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  err_e               err_q, err_d;
  kind_e              kind_q, kind_d;
  logic               last_q, last_d;
  logic [ValW-1:0]    left_q, left_d;
  logic [ValW-1:0]    right_q, right_d;
  logic [ValW-1:0]    res_q, res_d;
  logic [ValW-1:0]    rem_q, rem_d;
  logic [ValW-1:0]    quo_q, quo_d;
  logic [ValW-1:0]    dvsr_q, dvsr_d;
  logic [2:0]         dcnt_q, dcnt_d;
  logic               out_valid_q, out_valid_d;
  logic [ValW-1:0]    out_value_q, out_value_d;
  err_e               out_status_q, out_status_d;

  logic               ram_we;
  logic [AddrW-1:0]   ram_waddr, ram_raddr;
  logic [ValW-1:0]    ram_wdata, ram_rdata;
  logic [CntW-1:0]    cnt_m1;
  logic               empty, full, out_free;

  function automatic err_e note(err_e cur, err_e code);
    return (cur == ERR_NONE) ? code : cur;
  endfunction

  assign cnt_m1   = cnt_q - CntW'(1);
  assign empty    = (cnt_q == '0);
  assign full     = (cnt_q >= StackDepthC);
  assign out_free = !out_valid_q || out_ready_i;

  pse_ram #(
    .Width (ValW),
    .Depth (StackDepth)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          unique case (item_i.kind)
            KIND_PUSH: state_d = ST_PUSH;
            KIND_NOP:  state_d = item_i.last ? ST_FIN_RD : ST_IDLE;
            default:   state_d = ST_RD_R;
          endcase
        end
      end
      ST_RD_R:    state_d = empty ? ST_RD_L : ST_CAP_R;
      ST_CAP_R:   state_d = ST_RD_L;
      ST_RD_L:    state_d = empty ? ST_EXEC : ST_CAP_L;
      ST_CAP_L:   state_d = ST_EXEC;
      ST_EXEC: begin
        if ((kind_q == KIND_DIV || kind_q == KIND_MOD) && right_q != '0) begin
          state_d = ST_DIV;
        end else begin
          state_d = ST_PUSH;
        end
      end
      ST_DIV:     state_d = (dcnt_q == DivLastStep) ? ST_DIV_FIN : ST_DIV;
      ST_DIV_FIN: state_d = ST_PUSH;
      ST_PUSH:    state_d = last_q ? ST_FIN_RD : ST_IDLE;
      ST_FIN_RD:  state_d = empty ? ST_EMIT : ST_FIN_CAP;
      ST_FIN_CAP: state_d = ST_EMIT;
      ST_EMIT:    state_d = out_free ? ST_IDLE : ST_EMIT;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    logic [2*ValW-1:0] prod;
    logic [ValW:0]     shifted;
    logic [ValW:0]     diff;
    logic              neg_l, neg_r;

    cnt_d        = cnt_q;
    err_d        = err_q;
    kind_d       = kind_q;
    last_d       = last_q;
    left_d       = left_q;
    right_d      = right_q;
    res_d        = res_q;
    rem_d        = rem_q;
    quo_d        = quo_q;
    dvsr_d       = dvsr_q;
    dcnt_d       = dcnt_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    ram_we       = 1'b0;
    ram_waddr    = cnt_q[AddrW-1:0];
    ram_wdata    = res_q;
    ram_raddr    = cnt_m1[AddrW-1:0];
    item_ready_o = 1'b0;
    prod         = left_q * right_q;
    shifted      = {rem_q, quo_q[ValW-1]};
    diff         = shifted - {1'b0, dvsr_q};
    neg_l        = left_q[ValW-1];
    neg_r        = right_q[ValW-1];

    unique case (state_q)
      ST_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          kind_d = item_i.kind;
          last_d = item_i.last;
          res_d  = item_i.value;
        end
      end
      ST_RD_R: begin
        if (empty) begin
          err_d   = note(err_q, ERR_UNDER);
          right_d = '0;
        end else begin
          cnt_d = cnt_m1;
        end
      end
      ST_CAP_R: right_d = ram_rdata;
      ST_RD_L: begin
        if (empty) begin
          err_d  = note(err_q, ERR_UNDER);
          left_d = '0;
        end else begin
          cnt_d = cnt_m1;
        end
      end
      ST_CAP_L: left_d = ram_rdata;
      ST_EXEC: begin
        case (kind_q) inside
          KIND_ADD: res_d = left_q + right_q;
          KIND_SUB: res_d = left_q - right_q;
          KIND_MUL: res_d = prod[ValW-1:0];
          KIND_DIV, KIND_MOD: begin
            if (right_q == '0) begin
              err_d = note(err_q, ERR_DIVZ);
              res_d = '0;
            end else begin
              quo_d  = neg_l ? -left_q : left_q;
              dvsr_d = neg_r ? -right_q : right_q;
              rem_d  = '0;
              dcnt_d = '0;
            end
          end
          default: res_d = '0;
        endcase
      end
      ST_DIV: begin
        dcnt_d = dcnt_q + 3'd1;
        if (!diff[ValW]) begin
          rem_d = diff[ValW-1:0];
          quo_d = {quo_q[ValW-2:0], 1'b1};
        end else begin
          rem_d = shifted[ValW-1:0];
          quo_d = {quo_q[ValW-2:0], 1'b0};
        end
      end
      ST_DIV_FIN: begin
        if (kind_q == KIND_DIV) begin
          res_d = (neg_l ^ neg_r) ? -quo_q : quo_q;
        end else begin
          res_d = neg_l ? -rem_q : rem_q;
        end
      end
      ST_PUSH: begin
        if (full) begin
          err_d = note(err_q, ERR_OVER);
        end else begin
          ram_we = 1'b1;
          cnt_d  = cnt_q + CntW'(1);
        end
      end
      ST_FIN_RD: begin
        if (empty) begin
          err_d = note(err_q, ERR_UNDER);
          res_d = '0;
        end
      end
      ST_FIN_CAP: res_d = ram_rdata;
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_value_d  = res_q;
          out_status_d = err_q;
          cnt_d        = '0;
          err_d        = ERR_NONE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      err_q       <= ERR_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    last_q       <= last_d;
    left_q       <= left_d;
    right_q      <= right_d;
    res_q        <= res_d;
    rem_q        <= rem_d;
    quo_q        <= quo_d;
    dvsr_q       <= dvsr_d;
    dcnt_q       <= dcnt_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_value_o  = out_value_q;
  assign out_status_o = out_status_q;

endmodule

// ===== tb/sv/pse_checker.sv =====
// Checker for the postfix stack evaluator: predicts each result word and compares it.
// Watches both stream channels and keeps its own copy of the value stack.
// Depends on pse_pkg for the stack geometry, character codes and error codes.
module pse_checker
  import pse_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,    // [7:0] symbol
  input  logic        s_tlast_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [15:0] m_tdata_i,    // [7:0] value, [9:8] status, [15:10] zero
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [ValW-1:0] value;
    err_e            status;
  } outcome_t;

  logic [ValW-1:0] stack_mem [StackDepth];
  int unsigned     depth_used = 0;
  err_e            err_seen = ERR_NONE;
  outcome_t        outcome_q [$];
  int              mismatches = 0;

  function automatic void note_err(err_e code);
    if (err_seen == ERR_NONE) begin
      err_seen = code;
    end
  endfunction

  function automatic void push_entry(logic [ValW-1:0] v);
    if (depth_used >= StackDepth) begin
      note_err(ERR_OVER);
    end else begin
      stack_mem[depth_used] = v;
      depth_used++;
    end
  endfunction

  function automatic logic [ValW-1:0] pop_entry();
    if (depth_used == 0) begin
      note_err(ERR_UNDER);
      return '0;
    end
    depth_used--;
    return stack_mem[depth_used];
  endfunction

  task automatic eval_symbol(logic [7:0] sym, logic fin);
    int       rhs;
    int       lhs;
    int       res;
    outcome_t got;
    res = 0;
    if (sym inside {ChPlus, ChMinus, ChStar, ChSlash, ChPercent}) begin
      rhs = int'($signed(pop_entry()));
      lhs = int'($signed(pop_entry()));
      case (sym)
        ChPlus:  res = lhs + rhs;
        ChMinus: res = lhs - rhs;
        ChStar:  res = lhs * rhs;
        default: begin
          if (rhs == 0) begin
            note_err(ERR_DIVZ);
          end else if (sym == ChSlash) begin
            res = lhs / rhs;
          end else begin
            res = lhs % rhs;
          end
        end
      endcase
      push_entry(res[ValW-1:0]);
    end else if (!(sym inside {ChLeftPar, ChRightPar, ChHash})) begin
      push_entry(sym - CodeBias);
    end
    if (fin) begin
      got.value  = pop_entry();
      got.status = err_seen;
      outcome_q.push_back(got);
      depth_used = 0;
      err_seen   = ERR_NONE;
    end
  endtask

  task automatic check_word(logic [15:0] word);
    outcome_t want;
    if (outcome_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("unexpected result word: value %0d status %0d",
                 $signed(word[7:0]), word[9:8]);
      end
      return;
    end
    want = outcome_q.pop_front();
    if (word[7:0] !== want.value || word[9:8] !== want.status) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("result mismatch: expected value %0d status %0d, got value %0d status %0d",
                 $signed(want.value), want.status, $signed(word[7:0]), word[9:8]);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_used = 0;
      err_seen   = ERR_NONE;
      outcome_q.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        eval_symbol(s_tdata_i, s_tlast_i);
      end
      if (m_tvalid_i && m_tready_i) begin
        check_word(m_tdata_i);
      end
      pending_o    <= outcome_q.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the postfix stack evaluator testbench: clock, reset, stimulus and verdict.
// Sends directed and random expressions under several idle and stall patterns.
// Depends on pse_pkg, postfix_stack_evaluator and pse_checker.
module tb_top
  import pse_pkg::*;
();

  localparam int WatchdogLimit = 4000;
  localparam int DrainCycles   = 40;
  localparam int ItemTarget    = 550;

  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;   // [7:0] symbol
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;         // [7:0] value, [9:8] status, [15:10] zero

  int         fail_count;
  int         pending;
  int         idle_pct     = 0;
  int         stall_pct    = 0;
  int         items_sent   = 0;
  int         quiet_cycles = 0;
  logic [7:0] expr_q [$];

  postfix_stack_evaluator dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  pse_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tlast_i    (s_tlast),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("[postfix_stack_evaluator] ERROR");
      $finish;
    end
  end

  task automatic send_word(logic [7:0] sym, logic fin);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= sym;
    s_tlast  <= fin;
    @(posedge clk);
    while (!s_tready) begin
      @(posedge clk);
    end
    items_sent++;
  endtask

  task automatic send_expr();
    foreach (expr_q[i]) begin
      send_word(expr_q[i], i == expr_q.size() - 1);
    end
    expr_q.delete();
  endtask

  task automatic push_text(string s);
    foreach (s[i]) begin
      expr_q.push_back(s[i]);
    end
  endtask

  task automatic wait_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
  endtask

  function automatic logic [7:0] pick_operand();
    logic [7:0] sym;
    if ($urandom_range(3) != 0) begin
      return 8'd48 + 8'($urandom_range(9));
    end
    do begin
      sym = 8'($urandom_range(255));
    end while (sym inside {ChPlus, ChMinus, ChStar, ChSlash, ChPercent,
                           ChLeftPar, ChRightPar, ChHash});
    return sym;
  endfunction

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(4))
      0:       return ChPlus;
      1:       return ChMinus;
      2:       return ChStar;
      3:       return ChSlash;
      default: return ChPercent;
    endcase
  endfunction

  task automatic build_wellformed(int n_operands);
    int depth;
    int remaining;
    depth     = 0;
    remaining = n_operands;
    while (remaining > 0 || depth > 1) begin
      if (remaining > 0 && (depth < 2 || $urandom_range(1) == 1)) begin
        expr_q.push_back(pick_operand());
        remaining--;
        depth++;
      end else begin
        expr_q.push_back(pick_operator());
        depth--;
      end
      if ($urandom_range(19) == 0) begin
        case ($urandom_range(2))
          0:       expr_q.push_back(ChLeftPar);
          1:       expr_q.push_back(ChRightPar);
          default: expr_q.push_back(ChHash);
        endcase
      end
    end
  endtask

  initial begin
    int pick;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: byte extremes, each operator, skipped characters, the
    // -128 by -1 corner for both divide and modulo, divide by zero and
    // underflow, including a final pop from an empty stack.
    expr_q.push_back(8'h00);
    send_expr();
    expr_q.push_back(8'hFF);
    expr_q.push_back(8'h00);
    expr_q.push_back(ChMinus);
    send_expr();
    push_text("75*");
    send_expr();
    push_text("(83+)");
    send_expr();
    expr_q.push_back(8'hB0);
    push_text("01-/");
    send_expr();
    expr_q.push_back(8'hB0);
    push_text("01-%");
    send_expr();
    push_text("50/");
    send_expr();
    push_text("+");
    send_expr();
    push_text("#");
    send_expr();
    wait_results();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 71; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 71; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase
      while (items_sent < (ItemTarget * (phase + 1)) / 4) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          build_wellformed($urandom_range(8, 1));
        end else if (pick < 75) begin
          // Flood the stack near or past its depth; more than 32 operands overflow it.
          repeat ($urandom_range(36, 30)) expr_q.push_back(pick_operand());
          repeat ($urandom_range(4)) expr_q.push_back(pick_operator());
        end else if (pick < 90) begin
          repeat ($urandom_range(10, 1)) begin
            if ($urandom_range(1) == 1) begin
              expr_q.push_back(pick_operator());
            end else begin
              expr_q.push_back(8'($urandom_range(255)));
            end
          end
        end else begin
          send_word(8'($urandom_range(255)), $urandom_range(3) == 0);
        end
        send_expr();
      end
      wait_results();
    end

    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[postfix_stack_evaluator] OK");
    end else begin
      $display("[postfix_stack_evaluator] ERROR");
    end
    $finish;
  end

endmodule
